@@ hw/rtl/cell_toggle_slot_pool_unit_defines.svh @@
// Assertion helpers for the slot pool unit.
// Both sample on the rising edge of i_clk and are off while i_rst_n is low.
`ifndef CELL_TOGGLE_SLOT_POOL_UNIT_DEFINES_SVH
`define CELL_TOGGLE_SLOT_POOL_UNIT_DEFINES_SVH

// Same-cycle implication.
`define CTSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CTSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/ctsp_pkg.sv @@
package ctsp_pkg;

    localparam int POOL_DEPTH  = 1024;
    localparam int COORD_BITS  = 12;
    localparam int SLOT_BITS   = $clog2(POOL_DEPTH);
    localparam int COUNT_BITS  = SLOT_BITS + 1;
    localparam int CELL_BITS   = 2 * COORD_BITS;

    typedef logic [SLOT_BITS-1:0]  t_slot;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [CELL_BITS-1:0]  t_cell;

    // item opcodes
    localparam logic OP_TOGGLE = 1'b0;
    localparam logic OP_ADD    = 1'b1;

    // result status codes
    localparam logic [1:0] ST_ADDED   = 2'd0;
    localparam logic [1:0] ST_REMOVED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

endpackage

@@ hw/rtl/cell_toggle_slot_pool_unit.sv @@
// A toggle walks the active list and, on a hit, removes the entry: the last list
// entry fills the hole and the slot is freed. A toggle that misses, or an add, scans
// for the lowest free slot below the high-water count and appends it to the list,
// or reports the pool full. One item at a time: o_in_stall is high until it is done.
// Reset (synchronous, i_rst_n low): list empty, no slots used; no clearing pass.
`include "cell_toggle_slot_pool_unit_defines.svh"

module cell_toggle_slot_pool_unit
    import ctsp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input item channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_op,
    input  logic [COORD_BITS-1:0] i_cell_x,
    input  logic [COORD_BITS-1:0] i_cell_y,
    // result item channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_status,
    output logic [SLOT_BITS-1:0]  o_slot,
    output logic [SLOT_BITS-1:0]  o_list_position,
    output logic [COUNT_BITS-1:0] o_active_count
);

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SEARCH   = 3'd1; // walk active list, compare cells
    localparam logic [2:0] S_RM_RD    = 3'd2; // fetch last list entry
    localparam logic [2:0] S_RM_WR    = 3'd3; // fill hole, free slot
    localparam logic [2:0] S_SCAN     = 3'd4; // find lowest free slot
    localparam logic [2:0] S_ALLOC_WR = 3'd5; // store cell, append slot
    localparam logic [2:0] S_FULL     = 3'd6; // report pool full

    localparam t_count DEPTH_CNT = COUNT_BITS'(POOL_DEPTH);

    // Storage. Slot marks only exist below the high-water count r_hwm:
    // allocation always takes the lowest free slot, so every slot below
    // r_hwm has been written, and every slot at or above it is free.
    t_cell mem_pos  [POOL_DEPTH];
    t_slot mem_list [POOL_DEPTH];
    logic  mem_act  [POOL_DEPTH];

    logic [2:0] r_state, n_state;
    t_count     r_len, n_len;
    t_count     r_hwm, n_hwm;

    // latched item
    t_cell      r_cell;

    // list search pipeline: issue -> list data -> cell data -> compare
    t_count     r_iss, n_iss;
    logic       r_v1, n_v1;
    t_slot      r_k1, n_k1;
    logic       r_v2, n_v2;
    t_slot      r_k2, n_k2;
    t_slot      r_s2, n_s2;

    // free-slot scan: issue -> mark data
    t_count     r_sc, n_sc;
    logic       r_av, n_av;
    t_slot      r_ai, n_ai;
    t_slot      r_fs, n_fs;

    // registered memory read data
    t_slot      r_list_q;
    t_cell      r_pos_q;
    logic       r_act_q;

    // output register
    logic       r_o_valid;
    logic [1:0] r_o_status, n_o_status;
    t_slot      r_o_slot, n_o_slot;
    t_slot      r_o_pos, n_o_pos;
    t_count     r_o_cnt, n_o_cnt;
    logic       out_load;

    logic       in_accept;
    logic       out_free;
    logic       hit;
    t_count     len_m1;
    logic [2:0] alloc_state;

    t_slot      list_raddr;
    t_slot      act_raddr;
    logic       list_we, pos_we, act_we;
    t_slot      list_waddr, act_waddr;
    t_slot      list_wdata;
    logic       act_wdata;

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free  = !r_o_valid || !i_out_stall;
    assign hit       = r_v2 && (r_pos_q == r_cell);
    assign len_m1    = r_len - COUNT_BITS'(1);

    // Where an allocation starts: pool full is known from the list length.
    assign alloc_state = (r_len >= DEPTH_CNT) ? S_FULL : S_SCAN;

    // Read addresses: search walks the list, otherwise the last entry is
    // presented so it is ready for a removal.
    assign list_raddr = (r_state == S_SEARCH) ? r_iss[SLOT_BITS-1:0]
                                              : len_m1[SLOT_BITS-1:0];
    assign act_raddr  = r_sc[SLOT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        r_list_q <= mem_list[list_raddr];
        r_pos_q  <= mem_pos[r_list_q];
        r_act_q  <= mem_act[act_raddr];
        if (list_we) begin
            mem_list[list_waddr] <= list_wdata;
        end
        if (pos_we) begin
            mem_pos[r_fs] <= r_cell;
        end
        if (act_we) begin
            mem_act[act_waddr] <= act_wdata;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_hwm      = r_hwm;
        n_iss      = r_iss;
        n_v1       = r_v1;
        n_k1       = r_k1;
        n_v2       = r_v2;
        n_k2       = r_k2;
        n_s2       = r_s2;
        n_sc       = r_sc;
        n_av       = r_av;
        n_ai       = r_ai;
        n_fs       = r_fs;
        out_load   = 1'b0;
        n_o_status = r_o_status;
        n_o_slot   = r_o_slot;
        n_o_pos    = r_o_pos;
        n_o_cnt    = r_o_cnt;
        list_we    = 1'b0;
        list_waddr = r_k2;
        list_wdata = r_list_q;
        pos_we     = 1'b0;
        act_we     = 1'b0;
        act_waddr  = r_s2;
        act_wdata  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                n_iss = '0;
                n_v1  = 1'b0;
                n_v2  = 1'b0;
                n_sc  = '0;
                n_av  = 1'b0;
                if (in_accept) begin
                    if (i_op == OP_TOGGLE && r_len != '0) begin
                        n_state = S_SEARCH;
                    end else begin
                        n_state = alloc_state;
                    end
                end
            end

            S_SEARCH: begin
                if (hit) begin
                    // hold r_k2 / r_s2 as the removal target
                    n_state = S_RM_RD;
                end else if (!r_v1 && !r_v2 && r_iss >= r_len) begin
                    n_state = alloc_state;
                end else begin
                    n_v1 = (r_iss < r_len);
                    n_k1 = r_iss[SLOT_BITS-1:0];
                    if (r_iss < r_len) begin
                        n_iss = r_iss + COUNT_BITS'(1);
                    end
                    n_v2 = r_v1;
                    n_k2 = r_k1;
                    n_s2 = r_list_q;
                end
            end

            S_RM_RD: begin
                n_state = S_RM_WR;
            end

            S_RM_WR: begin
                // r_list_q holds the last list entry
                if (out_free) begin
                    list_we    = 1'b1;
                    list_waddr = r_k2;
                    list_wdata = r_list_q;
                    act_we     = 1'b1;
                    act_waddr  = r_s2;
                    act_wdata  = 1'b0;
                    n_len      = len_m1;
                    out_load   = 1'b1;
                    n_o_status = ST_REMOVED;
                    n_o_slot   = r_s2;
                    n_o_pos    = r_k2;
                    n_o_cnt    = len_m1;
                    n_state    = S_IDLE;
                end
            end

            S_SCAN: begin
                if (r_av && !r_act_q) begin
                    n_fs    = r_ai;
                    n_state = S_ALLOC_WR;
                end else if (!r_av && r_sc >= r_hwm) begin
                    // nothing free below the high-water count
                    n_fs    = r_hwm[SLOT_BITS-1:0];
                    n_state = S_ALLOC_WR;
                end else begin
                    n_av = (r_sc < r_hwm);
                    n_ai = r_sc[SLOT_BITS-1:0];
                    if (r_sc < r_hwm) begin
                        n_sc = r_sc + COUNT_BITS'(1);
                    end
                end
            end

            S_ALLOC_WR: begin
                if (out_free) begin
                    pos_we     = 1'b1;
                    act_we     = 1'b1;
                    act_waddr  = r_fs;
                    act_wdata  = 1'b1;
                    list_we    = 1'b1;
                    list_waddr = r_len[SLOT_BITS-1:0];
                    list_wdata = r_fs;
                    n_len      = r_len + COUNT_BITS'(1);
                    if ({1'b0, r_fs} >= r_hwm) begin
                        n_hwm = r_hwm + COUNT_BITS'(1);
                    end
                    out_load   = 1'b1;
                    n_o_status = ST_ADDED;
                    n_o_slot   = r_fs;
                    n_o_pos    = r_len[SLOT_BITS-1:0];
                    n_o_cnt    = r_len + COUNT_BITS'(1);
                    n_state    = S_IDLE;
                end
            end

            S_FULL: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_o_status = ST_FULL;
                    n_o_slot   = '0;
                    n_o_pos    = '0;
                    n_o_cnt    = r_len;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_hwm     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_hwm   <= n_hwm;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cell <= {i_cell_y, i_cell_x};
        end
        r_iss      <= n_iss;
        r_v1       <= n_v1;
        r_k1       <= n_k1;
        r_v2       <= n_v2;
        r_k2       <= n_k2;
        r_s2       <= n_s2;
        r_sc       <= n_sc;
        r_av       <= n_av;
        r_ai       <= n_ai;
        r_fs       <= n_fs;
        r_o_status <= n_o_status;
        r_o_slot   <= n_o_slot;
        r_o_pos    <= n_o_pos;
        r_o_cnt    <= n_o_cnt;
    end

    assign o_out_valid     = r_o_valid;
    assign o_status        = r_o_status;
    assign o_slot          = r_o_slot;
    assign o_list_position = r_o_pos;
    assign o_active_count  = r_o_cnt;

    // an add item never searches the list
    `CTSP_ASSERT_NEXT(a_add_no_search, in_accept && i_op == OP_ADD, r_state != S_SEARCH,
        "add item entered list search")
    // every active slot lies below the high-water count
    `CTSP_ASSERT_NOW(a_hwm_covers, 1'b1, r_hwm >= r_len,
        "high-water count below list length")
    // search never issues past the list end
    `CTSP_ASSERT_NOW(a_iss_bound, r_state == S_SEARCH, r_iss <= r_len,
        "search issued past list end")
    // a committed allocation grows the list by one
    `CTSP_ASSERT_NEXT(a_alloc_len, r_state == S_ALLOC_WR && out_free,
        r_len == $past(r_len) + COUNT_BITS'(1), "allocation did not grow list")
    // a committed removal shrinks the list by one
    `CTSP_ASSERT_NEXT(a_remove_len, r_state == S_RM_WR && out_free,
        r_len == $past(r_len) - COUNT_BITS'(1), "removal did not shrink list")

endmodule
